// ===== src/cdlz_pkg.sv =====
// ----------------------------------------------------------------------------
// cdlz_pkg
// Shared types and constants of the context-dictionary LZ decoder: the
// transaction payloads, status and register codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdlz_pkg;

  // Fixed field widths.
  localparam int unsigned POS_W     = 17;  // write position, area end, limit
  localparam int unsigned CTX_W     = 16;  // context position and stored offsets
  localparam int unsigned LEN_W     = 6;   // match length
  localparam int unsigned CODE_W    = 11;
  localparam int unsigned KEY_W     = 8;   // context byte
  localparam int unsigned CONTEXTS  = 256;
  localparam int unsigned POS_MAX   = 131071;

  // Token code regions.
  localparam logic [CODE_W-1:0] CODE_SPLIT = 11'd512;
  localparam logic [CODE_W-1:0] LIT_BASE   = 11'd1024;
  localparam logic [LEN_W:0]    LEN_BIAS   = 7'd2;

  // Opcode of an input transaction.
  localparam logic OP_START = 1'b0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVER    = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_LIMIT   = 2'd3
  } status_e;

  typedef enum logic {
    REG_AREA_END    = 1'b0,
    REG_CHUNK_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              opcode;
    logic [CODE_W-1:0] token_code;
    logic [LEN_W-1:0]  match_extra;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [CTX_W-1:0] out_pos;
    logic [1:0]       status;
    logic             last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load_item;
    logic    clear_area;
    logic    clear_step;
    logic    rd_key;
    logic    rd_row;
    logic    rd_entry;
    logic    load_match;
    logic    rd_src;
    logic    emit_copy;
    logic    emit_lit;
    logic    register_str;
    logic    emit_status;
    status_e status_code;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_start;
    logic at_limit;
    logic is_literal;
    logic overrun;
    logic illegal;
    logic last_copy;
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/cdlz_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdlz_ctrl
// Sequencer of the decoder: walks each token through the limit check, key
// lookup, dictionary lookup, byte copy and string registration as the token
// needs them, emits status results, and runs the dictionary clearing sweep.
// ----------------------------------------------------------------------------
module cdlz_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cdlz_pkg::sts_t sts_i,
  output cdlz_pkg::cmd_t cmd_o
);
  import cdlz_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_KEY, S_ROW, S_ENT,
    S_RD, S_WR, S_LIT, S_REG, S_STATUS
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  // The block takes a transaction only when it is idle.
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.status_code = code_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.is_start) begin
          cmd_o.clear_area = 1'b1;
          state_d = S_CLEAR;
        end else if (sts_i.at_limit) begin
          code_d  = ST_LIMIT;
          state_d = S_STATUS;
        end else begin
          cmd_o.rd_key = 1'b1;
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        cmd_o.rd_row = 1'b1;
        state_d = S_ROW;
      end
      S_ROW: begin
        if (sts_i.is_literal) begin
          state_d = S_LIT;
        end else begin
          cmd_o.rd_entry = 1'b1;
          state_d = S_ENT;
        end
      end
      S_ENT: begin
        if (sts_i.overrun) begin
          code_d  = ST_OVER;
          state_d = S_STATUS;
        end else if (sts_i.illegal) begin
          code_d  = ST_ILLEGAL;
          state_d = S_STATUS;
        end else begin
          cmd_o.load_match = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_src = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_copy = 1'b1;
          state_d = sts_i.last_copy ? S_REG : S_RD;
        end
      end
      S_LIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_lit = 1'b1;
          state_d = S_REG;
        end
      end
      S_REG: begin
        cmd_o.register_str = 1'b1;
        state_d = S_IDLE;
      end
      S_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered status code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

// ===== src/cdlz_datapath.sv =====
// ----------------------------------------------------------------------------
// cdlz_datapath
// History buffer, dictionary entry and context row memories, positions,
// configuration registers and the output register of the decoder.
// ----------------------------------------------------------------------------
module cdlz_datapath #(
  parameter int unsigned BUF_SIZE   = 65536,
  parameter int unsigned DICT_DEPTH = 512,
  parameter int unsigned MAX_MATCH  = 63
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cdlz_pkg::cmd_t             cmd_i,
  output cdlz_pkg::sts_t             sts_o,
  input  cdlz_pkg::in_item_t         in_data_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [cdlz_pkg::POS_W-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cdlz_pkg::out_item_t        out_data_o
);
  import cdlz_pkg::*;

  localparam int unsigned BUF_AW  = $clog2(BUF_SIZE);
  localparam int unsigned DICT_AW = $clog2(DICT_DEPTH);
  localparam int unsigned ENT_AW  = KEY_W + DICT_AW;
  localparam int unsigned ENT_W   = CTX_W + LEN_W;
  localparam int unsigned ROW_W   = DICT_AW + DICT_DEPTH;
  localparam int unsigned END_CAP = (BUF_SIZE < POS_MAX) ? BUF_SIZE : POS_MAX;

  // Memories.
  logic [7:0]       hist_mem [BUF_SIZE];
  logic [ENT_W-1:0] ent_mem  [CONTEXTS * DICT_DEPTH];
  logic [ROW_W-1:0] row_mem  [CONTEXTS];

  // Control registers.
  logic [POS_W-1:0] area_end_q, chunk_limit_q;
  logic [POS_W-1:0] wp_q;
  logic [CTX_W-1:0] cp_q;
  logic [KEY_W-1:0] clr_q;
  logic             out_valid_q;

  // Payload registers.
  in_item_t           item_q;
  logic [KEY_W-1:0]   key_q;
  logic [DICT_AW-1:0] slot_q;
  logic [LEN_W-1:0]   size_q, cnt_q;
  logic [CTX_W-1:0]   src_q;
  logic [7:0]         hist_rdata_q;
  logic [ENT_W-1:0]   ent_rdata_q;
  logic [ROW_W-1:0]   row_rdata_q;
  out_item_t          out_q;

  // Decode and checks.
  logic [POS_W-1:0]      end_w, limit_w;
  logic [DICT_AW-1:0]    ring_w, slot_w;
  logic [DICT_DEPTH-1:0] valid_w, valid_set_w;
  logic                  entry_valid_w, explicit_w, do_reg_w;
  logic [LEN_W:0]        ext2_w;
  logic [LEN_W-1:0]      exp_len_w, size_w;
  logic [CTX_W-1:0]      off_w;
  logic [BUF_AW-1:0]     hist_raddr_w, hist_waddr_w;
  logic [7:0]            hist_wdata_w;
  logic                  hist_we_w, hist_re_w, row_we_w, out_free_w;
  logic [KEY_W-1:0]      row_waddr_w;
  logic [ROW_W-1:0]      row_wdata_w;

  always_comb begin
    end_w   = (area_end_q < POS_W'(END_CAP)) ? area_end_q : POS_W'(END_CAP);
    limit_w = (chunk_limit_q < end_w) ? chunk_limit_q : end_w;

    valid_w = row_rdata_q[DICT_DEPTH-1:0];
    ring_w  = row_rdata_q[ROW_W-1:DICT_DEPTH];
    slot_w  = ring_w + DICT_AW'(item_q.token_code[8:0]);
    entry_valid_w = valid_w[slot_q];

    explicit_w = (item_q.token_code < CODE_SPLIT);
    ext2_w     = {1'b0, item_q.match_extra} + LEN_BIAS;
    exp_len_w  = (ext2_w > (LEN_W+1)'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : ext2_w[LEN_W-1:0];
    off_w      = ent_rdata_q[ENT_W-1:LEN_W];
    if (explicit_w)         size_w = exp_len_w;
    else if (entry_valid_w) size_w = ent_rdata_q[LEN_W-1:0];
    else                    size_w = '0;

    // Registration happens once the token moved past the context byte.
    do_reg_w = (POS_W'(cp_q) + POS_W'(1)) < wp_q;
    valid_set_w = valid_w;
    valid_set_w[ring_w] = 1'b1;

    hist_re_w    = cmd_i.rd_key | cmd_i.rd_src;
    hist_raddr_w = cmd_i.rd_key ? BUF_AW'(cp_q)
                                : BUF_AW'(POS_W'(src_q) + POS_W'(cnt_q));
    hist_we_w    = cmd_i.emit_copy | cmd_i.emit_lit;
    hist_waddr_w = BUF_AW'(wp_q);
    hist_wdata_w = cmd_i.emit_copy ? hist_rdata_q : item_q.token_code[7:0];

    row_we_w    = cmd_i.clear_step | (cmd_i.register_str & do_reg_w);
    row_waddr_w = cmd_i.clear_step ? clr_q : key_q;
    row_wdata_w = cmd_i.clear_step ? '0 : {ring_w + DICT_AW'(1), valid_set_w};

    out_free_w = !out_valid_q || !out_stall_i;
  end

  assign sts_o.is_start   = (item_q.opcode == OP_START);
  assign sts_o.at_limit   = (wp_q >= limit_w);
  assign sts_o.is_literal = (item_q.token_code >= LIT_BASE);
  assign sts_o.overrun    = ({1'b0, wp_q} + (POS_W+1)'(size_w)) > {1'b0, end_w};
  assign sts_o.illegal    = !entry_valid_w || (POS_W'(off_w) >= end_w);
  assign sts_o.last_copy  = (cnt_q + LEN_W'(1)) == size_q;
  assign sts_o.clear_last = (clr_q == KEY_W'(CONTEXTS - 1));
  assign sts_o.out_free   = out_free_w;

  // History buffer.
  always_ff @(posedge clk_i) begin
    if (hist_we_w) hist_mem[hist_waddr_w] <= hist_wdata_w;
    if (hist_re_w) hist_rdata_q <= hist_mem[hist_raddr_w];
  end

  // Dictionary entries: offset and length per context and ring slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.register_str && do_reg_w) begin
      ent_mem[{key_q, ring_w}] <= {cp_q + CTX_W'(1), size_q};
    end
    if (cmd_i.rd_entry) ent_rdata_q <= ent_mem[{key_q, slot_w}];
  end

  // Context rows: ring pointer and valid bits of each context.
  always_ff @(posedge clk_i) begin
    if (row_we_w)     row_mem[row_waddr_w] <= row_wdata_w;
    if (cmd_i.rd_row) row_rdata_q <= row_mem[hist_rdata_q];
  end

  // Configuration, positions, sweep counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_end_q    <= '0;
      chunk_limit_q <= '0;
      wp_q          <= '0;
      cp_q          <= '0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_AREA_END:    area_end_q    <= cfg_data_i;
          REG_CHUNK_LIMIT: chunk_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clear_area) begin
        wp_q  <= '0;
        cp_q  <= '0;
        clr_q <= '0;
      end else begin
        if (cmd_i.clear_step) clr_q <= clr_q + KEY_W'(1);
        if (hist_we_w) wp_q <= wp_q + POS_W'(1);
        if (cmd_i.register_str && do_reg_w) cp_q <= CTX_W'(wp_q - POS_W'(1));
      end
      if (cmd_i.emit_copy || cmd_i.emit_lit || cmd_i.emit_status) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Token, lookup and copy state, and the output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.rd_row) key_q <= hist_rdata_q;
    if (cmd_i.rd_entry) slot_q <= slot_w;
    if (cmd_i.load_match) begin
      size_q <= size_w;
      src_q  <= off_w;
      cnt_q  <= '0;
    end
    if (cmd_i.emit_copy) cnt_q <= cnt_q + LEN_W'(1);
    if (cmd_i.emit_lit) size_q <= LEN_W'(1);
    if (cmd_i.emit_copy) begin
      out_q.out_byte <= hist_rdata_q;
      out_q.out_pos  <= wp_q[CTX_W-1:0];
      out_q.status   <= ST_OK;
      out_q.last     <= sts_o.last_copy;
    end else if (cmd_i.emit_lit) begin
      out_q.out_byte <= item_q.token_code[7:0];
      out_q.out_pos  <= wp_q[CTX_W-1:0];
      out_q.status   <= ST_OK;
      out_q.last     <= 1'b1;
    end else if (cmd_i.emit_status) begin
      out_q.out_byte <= '0;
      out_q.out_pos  <= wp_q[CTX_W-1:0];
      out_q.status   <= cmd_i.status_code;
      out_q.last     <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/context_dictionary_lz_decoder.sv =====
// ----------------------------------------------------------------------------
// context_dictionary_lz_decoder
// Order-1 context LZ decoder: rebuilds output bytes from decoded tokens.
// ----------------------------------------------------------------------------
// The decoder takes one transaction at a time. A literal passes through the
// limit check, the key read, the row read, its output write and string
// registration; a match reads its dictionary entry instead and copies each
// byte as a registered read of the history buffer followed by its write,
// which keeps overlapping copies exact. A token stopped by the chunk limit,
// or rejected for overrun or illegal data, ends with a status output. A start
// transaction, and reset, run a clearing sweep over the 256 context rows (one
// row per cycle) during which no transaction is taken; configuration writes
// are taken at any time. Results leave through an output register, so a
// stalled result holds only the sequencer.
module context_dictionary_lz_decoder #(
  parameter int unsigned BUF_SIZE   = 65536,
  parameter int unsigned DICT_DEPTH = 512,
  parameter int unsigned MAX_MATCH  = 63
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cdlz_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cdlz_pkg::out_item_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [cdlz_pkg::POS_W-1:0] cfg_data_i
);
  import cdlz_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  cdlz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  cdlz_datapath #(
    .BUF_SIZE   (BUF_SIZE),
    .DICT_DEPTH (DICT_DEPTH),
    .MAX_MATCH  (MAX_MATCH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
